>>> rtl/atgr_pkg.sv
// Shared types, constants and the arctangent table for the tilt and rate unit.
package atgr_pkg;

    localparam int CORDIC_STAGES = 16;
    localparam int TABLE_LEN     = 24;
    localparam int STG_W         = $clog2(TABLE_LEN);
    localparam int SQRT_STEPS    = 16;
    localparam int XY_W          = 36;
    localparam int Z_W           = 25;
    localparam int Q_SHIFT       = 16;
    localparam int GYRO_DIV      = 131;
    // floor(2^23 / 131); quotient estimate is low by at most one
    localparam int RECIP         = 64035;
    localparam int RECIP_SHIFT   = 23;
    localparam int MAX_DEG       = 90;

    typedef struct packed {
        logic [31:0] val;
        logic [19:0] rem;
        logic [15:0] root;
        logic [15:0] mag;
        logic        neg;
        logic        nz;
    } sq_lane_t;

    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
        logic                   neg;
        logic                   nz;
        logic                   dz;
    } cd_lane_t;

    typedef struct packed {
        logic [8:0]  q0;
        logic [15:0] m;
        logic        neg;
    } rate_t;

    // atan(2^-i) in degrees, Q16, rounded to nearest
    function automatic logic [22:0] atan_q16(input logic [STG_W-1:0] i);
        logic [22:0] v;
        case (i)
            5'd0:  v = 23'd2949120;
            5'd1:  v = 23'd1740967;
            5'd2:  v = 23'd919879;
            5'd3:  v = 23'd466945;
            5'd4:  v = 23'd234379;
            5'd5:  v = 23'd117304;
            5'd6:  v = 23'd58666;
            5'd7:  v = 23'd29335;
            5'd8:  v = 23'd14668;
            5'd9:  v = 23'd7334;
            5'd10: v = 23'd3667;
            5'd11: v = 23'd1833;
            5'd12: v = 23'd917;
            5'd13: v = 23'd458;
            5'd14: v = 23'd229;
            5'd15: v = 23'd115;
            5'd16: v = 23'd57;
            5'd17: v = 23'd29;
            5'd18: v = 23'd14;
            5'd19: v = 23'd7;
            5'd20: v = 23'd4;
            5'd21: v = 23'd2;
            5'd22: v = 23'd1;
            default: v = 23'd0;
        endcase
        return v;
    endfunction

endpackage

>>> rtl/atgr_if.sv
// Sample and result channel interfaces.
interface atgr_sample_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic signed [15:0] gyro_x;
    logic signed [15:0] gyro_y;
    logic signed [15:0] gyro_z;

    modport source (output valid, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z,
                    input ready);
    modport sink (input valid, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z,
                  output ready);
endinterface

interface atgr_result_if;
    logic              valid;
    logic              ready;
    logic signed [7:0] tilt_x_deg;
    logic signed [7:0] tilt_y_deg;
    logic signed [7:0] tilt_z_deg;
    logic signed [8:0] rate_x_dps;
    logic signed [8:0] rate_y_dps;
    logic signed [8:0] rate_z_dps;

    modport source (output valid, tilt_x_deg, tilt_y_deg, tilt_z_deg,
                    rate_x_dps, rate_y_dps, rate_z_dps, input ready);
    modport sink (input valid, tilt_x_deg, tilt_y_deg, tilt_z_deg,
                  rate_x_dps, rate_y_dps, rate_z_dps, output ready);
endinterface

>>> rtl/atgr_front.sv
// Front stage: squares, sums and the gyro quotient estimate.
module atgr_front (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  logic                       in_valid,
    input  logic signed [15:0]         ax,
    input  logic signed [15:0]         ay,
    input  logic signed [15:0]         az,
    input  logic signed [15:0]         gx,
    input  logic signed [15:0]         gy,
    input  logic signed [15:0]         gz,
    output logic                       out_valid,
    output atgr_pkg::sq_lane_t [2:0]   lanes,
    output atgr_pkg::rate_t    [2:0]   rates
);
    import atgr_pkg::*;

    logic               valid_reg;
    sq_lane_t [2:0]     lanes_reg, lanes_next;
    rate_t    [2:0]     rates_reg, rates_next;
    logic signed [31:0] sx, sy, sz;
    logic signed [15:0] num [3];
    logic signed [15:0] g   [3];
    logic        [15:0] m   [3];
    logic        [31:0] p   [3];

    assign sx = ax * ax;
    assign sy = ay * ay;
    assign sz = az * az;
    assign num[0] = ay;
    assign num[1] = ax;
    assign num[2] = az;
    assign g[0] = gx;
    assign g[1] = gy;
    assign g[2] = gz;

    always_comb
    begin
        lanes_next[0].val = 32'(sx) + 32'(sz);
        lanes_next[1].val = 32'(sy) + 32'(sz);
        lanes_next[2].val = 32'(sx) + 32'(sy);
        for (int i = 0; i < 3; i++)
        begin
            lanes_next[i].rem  = '0;
            lanes_next[i].root = '0;
            lanes_next[i].mag  = num[i][15] ? 16'(-num[i]) : 16'(num[i]);
            lanes_next[i].neg  = num[i][15];
            lanes_next[i].nz   = (num[i] != 16'sd0);
            m[i] = g[i][15] ? 16'(-g[i]) : 16'(g[i]);
            p[i] = m[i] * 16'(RECIP);
            rates_next[i].q0  = p[i][31:RECIP_SHIFT];
            rates_next[i].m   = m[i];
            rates_next[i].neg = g[i][15];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lanes_reg <= lanes_next;
            rates_reg <= rates_next;
        end
    end

    assign out_valid = valid_reg;
    assign lanes     = lanes_reg;
    assign rates     = rates_reg;
endmodule

>>> rtl/atgr_sqrt_cell.sv
// One root digit for all three lanes, two radicand bits per cell.
module atgr_sqrt_cell (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  logic                       in_valid,
    input  atgr_pkg::sq_lane_t [2:0]   in_lanes,
    input  atgr_pkg::rate_t    [2:0]   in_rates,
    output logic                       out_valid,
    output atgr_pkg::sq_lane_t [2:0]   out_lanes,
    output atgr_pkg::rate_t    [2:0]   out_rates
);
    import atgr_pkg::*;

    logic           valid_reg;
    sq_lane_t [2:0] lanes_reg, lanes_next;
    rate_t    [2:0] rates_reg;
    logic [19:0]    rem_sh [3];
    logic [19:0]    trial  [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            lanes_next[i] = in_lanes[i];
            rem_sh[i] = {in_lanes[i].rem[17:0], in_lanes[i].val[31:30]};
            trial[i]  = {2'b00, in_lanes[i].root, 2'b01};
            lanes_next[i].val = {in_lanes[i].val[29:0], 2'b00};
            if (rem_sh[i] >= trial[i])
            begin
                lanes_next[i].rem  = rem_sh[i] - trial[i];
                lanes_next[i].root = {in_lanes[i].root[14:0], 1'b1};
            end
            else
            begin
                lanes_next[i].rem  = rem_sh[i];
                lanes_next[i].root = {in_lanes[i].root[14:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lanes_reg <= lanes_next;
            rates_reg <= in_rates;
        end
    end

    assign out_valid = valid_reg;
    assign out_lanes = lanes_reg;
    assign out_rates = rates_reg;
endmodule

>>> rtl/atgr_cordic_cell.sv
// One vectoring CORDIC rotation for all three lanes.
module atgr_cordic_cell (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            en,
    input  logic [atgr_pkg::STG_W-1:0]      stage,
    input  logic                            in_valid,
    input  atgr_pkg::cd_lane_t [2:0]        in_lanes,
    input  atgr_pkg::rate_t    [2:0]        in_rates,
    output logic                            out_valid,
    output atgr_pkg::cd_lane_t [2:0]        out_lanes,
    output atgr_pkg::rate_t    [2:0]        out_rates
);
    import atgr_pkg::*;

    logic                   valid_reg;
    cd_lane_t [2:0]         lanes_reg, lanes_next;
    rate_t    [2:0]         rates_reg;
    logic signed [XY_W-1:0] xs [3];
    logic signed [XY_W-1:0] ys [3];
    logic signed [Z_W-1:0]  da;

    assign da = $signed(Z_W'(atan_q16(stage)));

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            lanes_next[i] = in_lanes[i];
            xs[i] = in_lanes[i].x >>> stage;
            ys[i] = in_lanes[i].y >>> stage;
            if (!in_lanes[i].y[XY_W-1])
            begin
                lanes_next[i].x = in_lanes[i].x + ys[i];
                lanes_next[i].y = in_lanes[i].y - xs[i];
                lanes_next[i].z = in_lanes[i].z + da;
            end
            else
            begin
                lanes_next[i].x = in_lanes[i].x - ys[i];
                lanes_next[i].y = in_lanes[i].y + xs[i];
                lanes_next[i].z = in_lanes[i].z - da;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lanes_reg <= lanes_next;
            rates_reg <= in_rates;
        end
    end

    assign out_valid = valid_reg;
    assign out_lanes = lanes_reg;
    assign out_rates = rates_reg;
endmodule

>>> rtl/accel_tilt_and_gyro_rate_unit.sv
// Top level: tilt angles from accelerometer samples, rates from gyro samples.
//
//  channel  | dir | payload
//  sample   | in  | accel_x/y/z, gyro_x/y/z (s16)
//  result   | out | tilt_x/y/z_deg (s8), rate_x/y/z_dps (s9)
//
// One item per cycle while the chain is not stalled; the path is the front stage,
// one root cell per result bit, one CORDIC cell per rotation, and the output register.
// rst_n clears only the valid bits of the chain.
// The whole chain advances together; it holds while a result waits and
// result.ready is low, and fills bubbles otherwise.
module accel_tilt_and_gyro_rate_unit (
    input  logic          clk,
    input  logic          rst_n,
    atgr_sample_if.sink   sample,
    atgr_result_if.source result
);
    import atgr_pkg::*;

    logic en;
    logic           f_valid;
    sq_lane_t [2:0] f_lanes;
    rate_t    [2:0] f_rates;

    logic           sq_valid [SQRT_STEPS+1];
    sq_lane_t [2:0] sq_lanes [SQRT_STEPS+1];
    rate_t    [2:0] sq_rates [SQRT_STEPS+1];

    logic           cd_valid [CORDIC_STAGES+1];
    cd_lane_t [2:0] cd_lanes [CORDIC_STAGES+1];
    rate_t    [2:0] cd_rates [CORDIC_STAGES+1];

    logic              valid_reg;
    logic signed [7:0] tilt_reg [3];
    logic signed [8:0] rate_reg [3];
    logic signed [7:0] tilt_next [3];
    logic signed [8:0] rate_next [3];
    logic        [6:0] deg   [3];
    logic        [15:0] qm   [3];
    logic        [15:0] r    [3];
    logic        [8:0]  q    [3];

    assign en = !valid_reg || result.ready;
    assign sample.ready = en;

    atgr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (sample.valid),
        .ax        (sample.accel_x),
        .ay        (sample.accel_y),
        .az        (sample.accel_z),
        .gx        (sample.gyro_x),
        .gy        (sample.gyro_y),
        .gz        (sample.gyro_z),
        .out_valid (f_valid),
        .lanes     (f_lanes),
        .rates     (f_rates)
    );

    assign sq_valid[0] = f_valid;
    assign sq_lanes[0] = f_lanes;
    assign sq_rates[0] = f_rates;

    for (genvar k = 0; k < SQRT_STEPS; k++)
    begin : g_sqrt
        atgr_sqrt_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (sq_valid[k]),
            .in_lanes  (sq_lanes[k]),
            .in_rates  (sq_rates[k]),
            .out_valid (sq_valid[k+1]),
            .out_lanes (sq_lanes[k+1]),
            .out_rates (sq_rates[k+1])
        );
    end

    // root and numerator magnitude enter the CORDIC in Q16
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            cd_lanes[0][i].x   = $signed({4'b0000, sq_lanes[SQRT_STEPS][i].root, 16'h0000});
            cd_lanes[0][i].y   = $signed({4'b0000, sq_lanes[SQRT_STEPS][i].mag, 16'h0000});
            cd_lanes[0][i].z   = '0;
            cd_lanes[0][i].neg = sq_lanes[SQRT_STEPS][i].neg;
            cd_lanes[0][i].nz  = sq_lanes[SQRT_STEPS][i].nz;
            cd_lanes[0][i].dz  = (sq_lanes[SQRT_STEPS][i].root == 16'd0);
        end
    end
    assign cd_valid[0] = sq_valid[SQRT_STEPS];
    assign cd_rates[0] = sq_rates[SQRT_STEPS];

    for (genvar k = 0; k < CORDIC_STAGES; k++)
    begin : g_cordic
        atgr_cordic_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .stage     (STG_W'(k)),
            .in_valid  (cd_valid[k]),
            .in_lanes  (cd_lanes[k]),
            .in_rates  (cd_rates[k]),
            .out_valid (cd_valid[k+1]),
            .out_lanes (cd_lanes[k+1]),
            .out_rates (cd_rates[k+1])
        );
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (cd_lanes[CORDIC_STAGES][i].z[Z_W-1])
                deg[i] = 7'd0;
            else if (cd_lanes[CORDIC_STAGES][i].z[Z_W-2:Q_SHIFT] > 8'(MAX_DEG))
                deg[i] = 7'(MAX_DEG);
            else
                deg[i] = cd_lanes[CORDIC_STAGES][i].z[Q_SHIFT+6:Q_SHIFT];
            if (!cd_lanes[CORDIC_STAGES][i].nz)
                deg[i] = 7'd0;
            else if (cd_lanes[CORDIC_STAGES][i].dz)
                deg[i] = 7'(MAX_DEG);
            tilt_next[i] = cd_lanes[CORDIC_STAGES][i].neg ? $signed({1'b0, deg[i]})
                                                          : -$signed({1'b0, deg[i]});

            // quotient estimate corrected by one remainder compare
            qm[i] = 16'(cd_rates[CORDIC_STAGES][i].q0) * 16'(GYRO_DIV);
            r[i]  = cd_rates[CORDIC_STAGES][i].m - qm[i];
            q[i]  = cd_rates[CORDIC_STAGES][i].q0 + 9'(r[i] >= 16'(GYRO_DIV));
            rate_next[i] = cd_rates[CORDIC_STAGES][i].neg ? -$signed(q[i]) : $signed(q[i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= cd_valid[CORDIC_STAGES];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tilt_reg <= tilt_next;
            rate_reg <= rate_next;
        end
    end

    assign result.valid      = valid_reg;
    assign result.tilt_x_deg = tilt_reg[0];
    assign result.tilt_y_deg = tilt_reg[1];
    assign result.tilt_z_deg = tilt_reg[2];
    assign result.rate_x_dps = rate_reg[0];
    assign result.rate_y_dps = rate_reg[1];
    assign result.rate_z_dps = rate_reg[2];

    a_tilt_range: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (result.tilt_x_deg <= 8'sd90 && result.tilt_x_deg >= -8'sd90 &&
                          result.tilt_y_deg <= 8'sd90 && result.tilt_y_deg >= -8'sd90 &&
                          result.tilt_z_deg <= 8'sd90 && result.tilt_z_deg >= -8'sd90))
        else $error("tilt out of range");

    a_rate_range: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (result.rate_x_dps <= 9'sd250 && result.rate_x_dps >= -9'sd250 &&
                          result.rate_y_dps <= 9'sd250 && result.rate_y_dps >= -9'sd250 &&
                          result.rate_z_dps <= 9'sd250 && result.rate_z_dps >= -9'sd250))
        else $error("rate out of range");

    a_chain_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(cd_valid[CORDIC_STAGES]) && $stable(sq_valid[SQRT_STEPS]))
        else $error("chain moved during stall");
endmodule

>>> verif/accel_tilt_and_gyro_rate_unit_tb.sv
// Testbench for the tilt and rate unit: bit-exact predictor, random idling on both channels.
`timescale 1ns / 1ps

module accel_tilt_and_gyro_rate_unit_tb;
    import atgr_pkg::*;

    localparam int LATENCY   = 2 + 16 + CORDIC_STAGES;
    localparam int MAX_CYCLE = 400000;

    typedef struct packed {
        logic signed [7:0] tx;
        logic signed [7:0] ty;
        logic signed [7:0] tz;
        logic signed [8:0] rx;
        logic signed [8:0] ry;
        logic signed [8:0] rz;
    } angles_t;

    logic clk;
    logic rst_n;
    atgr_sample_if sample ();
    atgr_result_if result ();

    accel_tilt_and_gyro_rate_unit dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample.sink),
        .result (result.source)
    );

    angles_t   expected_angles[$];
    int        send_idle_pct;
    int        recv_stall_pct;
    int        cycle_count = 0;
    bit        failed = 1'b0;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // floor integer square root
    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v)
            b >>= 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v -= res + b;
                res = (res >> 1) + b;
            end
            else
                res >>= 1;
            b >>= 2;
        end
        return res;
    endfunction

    function automatic logic signed [7:0] tilt_deg(input longint num, input longint a,
                                                   input longint b);
        longint unsigned den;
        longint x, y, z, xs, ys, deg;
        longint atan_tab[TABLE_LEN];
        atan_tab = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
                     14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1, 0};
        den = int_sqrt(longint'(a * a + b * b));
        if (num == 0)
            return 8'sd0;
        if (den == 0)
            deg = 90;
        else
        begin
            x = longint'(den) <<< Q_SHIFT;
            y = (num < 0 ? -num : num) <<< Q_SHIFT;
            z = 0;
            for (int i = 0; i < CORDIC_STAGES && i < TABLE_LEN; i++)
            begin
                xs = x >>> i;
                ys = y >>> i;
                if (y >= 0)
                begin
                    x += ys;
                    y -= xs;
                    z += atan_tab[i];
                end
                else
                begin
                    x -= ys;
                    y += xs;
                    z -= atan_tab[i];
                end
            end
            if (z < 0)
                z = 0;
            deg = z >>> Q_SHIFT;
            if (deg > 90)
                deg = 90;
        end
        return num > 0 ? 8'(-deg) : 8'(deg);
    endfunction

    function automatic logic signed [8:0] gyro_rate(input longint g);
        longint m;
        m = (g < 0 ? -g : g) / GYRO_DIV;
        return g < 0 ? 9'(-m) : 9'(m);
    endfunction

    function automatic angles_t predict_angles(input logic signed [15:0] ax, ay, az,
                                               gx, gy, gz);
        angles_t r;
        r.tx = tilt_deg(ay, ax, az);
        r.ty = tilt_deg(ax, ay, az);
        r.tz = tilt_deg(az, ax, ay);
        r.rx = gyro_rate(gx);
        r.ry = gyro_rate(gy);
        r.rz = gyro_rate(gz);
        return r;
    endfunction

    task automatic send_sample(input logic [15:0] ax, ay, az, gx, gy, gz);
        while ($urandom_range(99) < send_idle_pct)
        begin
            sample.valid <= 1'b0;
            @(posedge clk);
        end
        sample.valid   <= 1'b1;
        sample.accel_x <= ax;
        sample.accel_y <= ay;
        sample.accel_z <= az;
        sample.gyro_x  <= gx;
        sample.gyro_y  <= gy;
        sample.gyro_z  <= gz;
        do
            @(posedge clk);
        while (!sample.ready);
        expected_angles.push_back(predict_angles(ax, ay, az, gx, gy, gz));
    endtask

    task automatic send_random_samples(input int n);
        logic [15:0] a[3];
        for (int k = 0; k < n; k++)
        begin
            foreach (a[j])
            begin
                case ($urandom_range(5))
                    0: a[j] = 16'h8000;
                    1: a[j] = 16'h7FFF;
                    2: a[j] = 16'($signed($urandom_range(64)) - 32);
                    default: a[j] = 16'($urandom);
                endcase
            end
            // equal magnitudes probe the 45 degree boundary
            if ($urandom_range(9) == 0)
                a[1] = $urandom_range(1) ? a[0] : -a[0];
            send_sample(a[0], a[1], a[2], 16'($urandom), 16'($urandom), 16'($urandom));
        end
    endtask

    task automatic wait_drained();
        sample.valid <= 1'b0;
        while (expected_angles.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_directed();
        send_sample(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_sample(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
        send_sample(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
        send_sample(16'h7FFF, 16'h0000, 16'h0000, 16'd131, -16'sd131, 16'd130);
        send_sample(16'h0000, 16'h8000, 16'h0000, -16'sd130, 16'd262, -16'sd262);
        send_sample(16'h0000, 16'h0000, 16'h0001, 16'h0001, 16'hFFFF, 16'd32750);
        send_sample(16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_sample(16'd1000, 16'd1000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_sample(-16'sd1000, 16'd1000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_sample(16'd3, 16'd4, 16'd0, 16'h0000, 16'h0000, 16'h0000);
        send_sample(16'h8000, 16'h7FFF, 16'h0001, 16'h5555, 16'hAAAA, 16'h0000);
        send_sample(16'd100, 16'd100, 16'd100, 16'h0000, 16'h0000, 16'h0000);
        send_sample(16'h0001, 16'h8000, 16'h7FFF, 16'h0000, 16'h0000, 16'h0000);
        wait_drained();
    endtask

    task automatic test_phase(input int idle_pct, input int stall_pct, input int n);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        send_random_samples(n);
    endtask

    always @(posedge clk)
    begin
        angles_t exp_a;
        angles_t act;
        cycle_count <= cycle_count + 1;
        if (cycle_count > MAX_CYCLE)
        begin
            $display("tb: failure");
            $finish;
        end
        result.ready <= ($urandom_range(99) >= recv_stall_pct);
        if (rst_n && result.valid && result.ready)
        begin
            act = '{result.tilt_x_deg, result.tilt_y_deg, result.tilt_z_deg,
                    result.rate_x_dps, result.rate_y_dps, result.rate_z_dps};
            if (expected_angles.size() == 0)
            begin
                $display("%0t unexpected result %p", $time, act);
                failed = 1'b1;
            end
            else
            begin
                exp_a = expected_angles.pop_front();
                if (act.tx !== exp_a.tx || act.ty !== exp_a.ty || act.tz !== exp_a.tz ||
                    act.rx !== exp_a.rx || act.ry !== exp_a.ry || act.rz !== exp_a.rz)
                begin
                    $display("%0t mismatch expected %p actual %p", $time, exp_a, act);
                    failed = 1'b1;
                end
            end
        end
    end

    initial
    begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        rst_n          = 1'b0;
        sample.valid   = 1'b0;
        sample.accel_x = '0;
        sample.accel_y = '0;
        sample.accel_z = '0;
        sample.gyro_x  = '0;
        sample.gyro_y  = '0;
        sample.gyro_z  = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_phase(0, 0, 100);
        test_phase(49, 0, 90);
        wait_drained();
        test_phase(0, 49, 90);
        test_phase(7, 7, 90);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        send_random_samples(30);
        wait_drained();
        repeat (LATENCY + 10) @(posedge clk);
        if (!failed && expected_angles.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule

>>> sim.f
rtl/atgr_pkg.sv
rtl/atgr_if.sv
rtl/atgr_front.sv
rtl/atgr_sqrt_cell.sv
rtl/atgr_cordic_cell.sv
rtl/accel_tilt_and_gyro_rate_unit.sv
verif/accel_tilt_and_gyro_rate_unit_tb.sv
